[hdl/nca_pkg.sv]
// nca_pkg: shared widths, codes and control structs for the nearest-centroid block
// used by nca_dist_unit, nca_counts and nearest_centroid_assign_core
package nca_pkg;

    localparam int VAL_W   = 16;
    localparam int DIST_W  = 39;
    localparam int COUNT_W = 32;
    localparam int NUM_W   = 7;
    localparam int LIST_FW = 6;
    localparam int ELEM_FW = 7;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 112;

    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef struct packed {
        logic valid;
        logic accum;
        logic compare;
        logic clear;
        logic first;
    } issue_ctl_t;

    typedef struct packed {
        logic clear;
        logic bump;
    } cnt_req_t;

endpackage

[hdl/nca_dist_unit.sv]
// nca_dist_unit: centroid memory, distance accumulator memory and the
// diff / square / accumulate pipeline with running minimum; uses nca_pkg
module nca_dist_unit #(
    parameter int MAX_LISTS = 64,
    parameter int MAX_DIM   = 128,
    parameter int LIST_W    = 6,
    parameter int DIM_W     = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_en,
    input  logic [LIST_W-1:0]           load_list,
    input  logic [DIM_W-1:0]            load_elem,
    input  logic [nca_pkg::VAL_W-1:0]   load_value,
    input  nca_pkg::issue_ctl_t         issue,
    input  logic [LIST_W-1:0]           issue_idx,
    input  logic [DIM_W-1:0]            query_elem,
    input  logic [nca_pkg::VAL_W-1:0]   query_value,
    output logic                        busy,
    output logic [LIST_W-1:0]           best_idx,
    output logic [nca_pkg::DIST_W-1:0]  min_dist
);
    import nca_pkg::*;

    localparam int CADDR_W = (MAX_LISTS * MAX_DIM > 1) ? $clog2(MAX_LISTS * MAX_DIM) : 1;

    logic [VAL_W-1:0]  cen_mem [MAX_LISTS * MAX_DIM];
    logic [DIST_W-1:0] acc_mem [MAX_LISTS];

    logic [CADDR_W-1:0] cen_waddr;
    logic [CADDR_W-1:0] cen_raddr;
    logic [VAL_W-1:0]   cen_rd_reg;
    logic [DIST_W-1:0]  acc_rd_reg;

    issue_ctl_t        s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [LIST_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [VAL_W-1:0]  s2_abs_reg;
    logic [DIST_W-1:0] s2_acc_reg, s3_acc_reg;
    logic [2*VAL_W-1:0] s3_sq_reg;

    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]        diff_abs;
    logic [DIST_W:0]       sum;
    logic [DIST_W-1:0]     sum_sat;
    logic [DIST_W-1:0]     acc_wdata;
    logic [DIST_W-1:0]     min_dist_reg;
    logic [LIST_W-1:0]     best_idx_reg;

    assign cen_waddr = CADDR_W'(load_list) * CADDR_W'(MAX_DIM) + CADDR_W'(load_elem);
    assign cen_raddr = CADDR_W'(issue_idx) * CADDR_W'(MAX_DIM) + CADDR_W'(query_elem);

    // centroid memory, one write and one read per cycle
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            cen_mem[cen_waddr] <= load_value;
        end
        if (issue.valid)
        begin
            cen_rd_reg <= cen_mem[cen_raddr];
        end
    end

    // accumulator memory, read at issue and written back from stage 3
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            acc_rd_reg <= acc_mem[issue_idx];
        end
        if (s3_ctl_reg.valid)
        begin
            acc_mem[s3_idx_reg] <= acc_wdata;
        end
    end

    always_comb
    begin
        diff     = $signed({query_value[VAL_W-1], query_value})
                 - $signed({cen_rd_reg[VAL_W-1], cen_rd_reg});
        diff_abs = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
        sum      = {1'b0, s3_acc_reg}
                 + (s3_ctl_reg.accum ? (DIST_W+1)'(s3_sq_reg) : '0);
        sum_sat  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        acc_wdata = s3_ctl_reg.clear ? '0 : sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= issue;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= issue_idx;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        s2_abs_reg <= diff_abs[VAL_W-1:0];
        s2_acc_reg <= acc_rd_reg;
        s3_acc_reg <= s2_acc_reg;
        s3_sq_reg  <= s2_abs_reg * s2_abs_reg;
        if (s3_ctl_reg.valid && s3_ctl_reg.compare
            && (s3_ctl_reg.first || (sum_sat < min_dist_reg)))
        begin
            min_dist_reg <= sum_sat;
            best_idx_reg <= s3_idx_reg;
        end
    end

    assign busy     = s1_ctl_reg.valid || s2_ctl_reg.valid || s3_ctl_reg.valid;
    assign best_idx = best_idx_reg;
    assign min_dist = min_dist_reg;

endmodule

[hdl/nca_counts.sv]
// nca_counts: per-list assignment count memory and saturating total counter
// read-modify-write: read into cnt_rd_reg, written back from the s1 stage; uses nca_pkg
module nca_counts #(
    parameter int MAX_LISTS = 64,
    parameter int LIST_W    = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nca_pkg::cnt_req_t            req,
    input  logic [LIST_W-1:0]            idx,
    output logic                         done,
    output logic [nca_pkg::COUNT_W-1:0]  list_count,
    output logic [nca_pkg::COUNT_W-1:0]  total
);
    import nca_pkg::*;

    logic [COUNT_W-1:0] cnt_mem [MAX_LISTS];
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [LIST_W-1:0]  s1_idx_reg;
    logic               s1_valid_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic [COUNT_W-1:0] total_next;

    assign cnt_next   = (cnt_rd_reg == COUNT_MAX) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
    assign total_next = (total_reg == COUNT_MAX) ? total_reg : total_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (req.bump)
        begin
            cnt_rd_reg <= cnt_mem[idx];
        end
        if (req.clear)
        begin
            cnt_mem[idx] <= '0;
        end
        else if (s1_valid_reg)
        begin
            cnt_mem[s1_idx_reg] <= cnt_next;
        end
        s1_idx_reg <= idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= req.bump;
            if (s1_valid_reg)
            begin
                total_reg <= total_next;
            end
        end
    end

    assign done       = s1_valid_reg;
    assign list_count = cnt_next;
    assign total      = total_next;

endmodule

[hdl/nearest_centroid_assign_core.sv]
// nearest_centroid_assign_core: a load item is written to centroid memory on acceptance; a query
// element sweeps the n active centroids; the last element sweeps all MAX_LISTS accumulators
// (compare and clear) and then returns a result; a null row clears all MAX_LISTS, with no result.
// rate is set by one centroid and one accumulator memory access per centroid per cycle.
// after reset a sweep over all MAX_LISTS entries clears accumulators and counts, s_axis_tready low.
// uses nca_pkg, nca_dist_unit, nca_counts
module nearest_centroid_assign_core #(
    parameter int MAX_LISTS = 64,
    parameter int MAX_DIM   = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [nca_pkg::NUM_W-1:0]       cfg_wr_data,     // active centroid count
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // list_index[5:0], element_index[12:6], element_value[28:13], zero[31:29]
    input  logic [nca_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action[0], is_null[1]
    input  logic [nca_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                            s_axis_tlast,    // last_element
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // nearest_list[5:0], min_distance[44:6], list_entry_count[76:45],
    // total_assigned[108:77], zero[111:109]
    output logic [nca_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import nca_pkg::*;

    localparam int LIST_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_LISTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_BUMP  = 5'b01000,
        ST_WAIT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [NUM_W-1:0]   list_limit_reg;
    logic [LIST_W-1:0]  pass_idx_reg, pass_idx_next;
    logic [CNT_W-1:0]   pass_end_reg, pass_end_next;
    logic [CNT_W-1:0]   pass_n_reg, pass_n_next;
    logic               mode_last_reg, mode_last_next;
    logic               mode_clear_reg, mode_clear_next;
    logic               mode_init_reg, mode_init_next;
    logic               elem_ok_reg, elem_ok_next;
    logic [DIM_W-1:0]   elem_reg;
    logic [VAL_W-1:0]   value_reg;

    logic               out_valid_reg;
    logic [LIST_FW-1:0] out_list_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_total_reg;

    logic [LIST_FW-1:0] in_list;
    logic [ELEM_FW-1:0] in_elem;
    logic [VAL_W-1:0]   in_value;
    logic               in_action;
    logic               in_null;
    logic               in_accept;
    logic               load_ok;
    logic [CNT_W-1:0]   active_n;
    logic               in_range;
    logic               issue_done;
    logic               out_free;

    issue_ctl_t         issue;
    cnt_req_t           cnt_req;
    logic [LIST_W-1:0]  cnt_idx;
    logic               dist_busy;
    logic [LIST_W-1:0]  best_idx;
    logic [DIST_W-1:0]  min_dist;
    logic               cnt_done;
    logic [COUNT_W-1:0] cnt_list;
    logic [COUNT_W-1:0] cnt_total;

    assign in_list   = s_axis_tdata[5:0];
    assign in_elem   = s_axis_tdata[12:6];
    assign in_value  = s_axis_tdata[28:13];
    assign in_action = s_axis_tuser[0];
    assign in_null   = s_axis_tuser[1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_ok       = (32'(in_list) < MAX_LISTS) && (32'(in_elem) < MAX_DIM);
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (list_limit_reg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (32'(list_limit_reg) > MAX_LISTS)
        begin
            active_n = CNT_W'(MAX_LISTS);
        end
        else
        begin
            active_n = CNT_W'(list_limit_reg);
        end
    end

    assign in_range   = CNT_W'(pass_idx_reg) < pass_n_reg;
    assign issue_done = (CNT_W'(pass_idx_reg) + CNT_W'(1)) == pass_end_reg;

    always_comb
    begin
        issue.valid   = (state_reg == ST_ISSUE);
        issue.accum   = !mode_clear_reg && elem_ok_reg && in_range;
        issue.compare = mode_last_reg && in_range;
        issue.clear   = mode_clear_reg || mode_last_reg;
        issue.first   = (pass_idx_reg == '0);
        cnt_req.clear = (state_reg == ST_ISSUE) && mode_init_reg;
        cnt_req.bump  = (state_reg == ST_BUMP) && out_free;
        cnt_idx       = (state_reg == ST_BUMP) ? best_idx : pass_idx_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        pass_idx_next   = pass_idx_reg;
        pass_end_next   = pass_end_reg;
        pass_n_next     = pass_n_reg;
        mode_last_next  = mode_last_reg;
        mode_clear_next = mode_clear_reg;
        mode_init_next  = mode_init_reg;
        elem_ok_next    = elem_ok_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_action == ACTION_QUERY))
                begin
                    state_next      = ST_ISSUE;
                    pass_idx_next   = '0;
                    pass_n_next     = active_n;
                    mode_init_next  = 1'b0;
                    mode_clear_next = in_null;
                    mode_last_next  = !in_null && s_axis_tlast;
                    elem_ok_next    = 32'(in_elem) < MAX_DIM;
                    pass_end_next   = (in_null || s_axis_tlast) ? CNT_W'(MAX_LISTS) : active_n;
                end
            end
            ST_ISSUE:
            begin
                pass_idx_next = pass_idx_reg + 1'b1;
                if (issue_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dist_busy)
                begin
                    state_next = mode_last_reg ? ST_BUMP : ST_IDLE;
                end
            end
            ST_BUMP:
            begin
                if (out_free)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (cnt_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ISSUE;
            list_limit_reg <= NUM_W'(1);
            pass_idx_reg   <= '0;
            pass_end_reg   <= CNT_W'(MAX_LISTS);
            pass_n_reg     <= CNT_W'(1);
            mode_last_reg  <= 1'b0;
            mode_clear_reg <= 1'b1;
            mode_init_reg  <= 1'b1;
            elem_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_idx_reg   <= pass_idx_next;
            pass_end_reg   <= pass_end_next;
            pass_n_reg     <= pass_n_next;
            mode_last_reg  <= mode_last_next;
            mode_clear_reg <= mode_clear_next;
            mode_init_reg  <= mode_init_next;
            elem_ok_reg    <= elem_ok_next;
            if (cfg_wr_en)
            begin
                list_limit_reg <= cfg_wr_data;
            end
            if (cnt_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            elem_reg  <= DIM_W'(in_elem);
            value_reg <= in_value;
        end
        if (cnt_done)
        begin
            out_list_reg  <= LIST_FW'(best_idx);
            out_dist_reg  <= min_dist;
            out_count_reg <= cnt_list;
            out_total_reg <= cnt_total;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_total_reg, out_count_reg, out_dist_reg, out_list_reg};

    nca_dist_unit #(
        .MAX_LISTS (MAX_LISTS),
        .MAX_DIM   (MAX_DIM),
        .LIST_W    (LIST_W),
        .DIM_W     (DIM_W)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (in_accept && (in_action == ACTION_LOAD) && load_ok),
        .load_list   (LIST_W'(in_list)),
        .load_elem   (DIM_W'(in_elem)),
        .load_value  (in_value),
        .issue       (issue),
        .issue_idx   (pass_idx_reg),
        .query_elem  (elem_reg),
        .query_value (value_reg),
        .busy        (dist_busy),
        .best_idx    (best_idx),
        .min_dist    (min_dist)
    );

    nca_counts #(
        .MAX_LISTS (MAX_LISTS),
        .LIST_W    (LIST_W)
    ) u_counts (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (cnt_req),
        .idx        (cnt_idx),
        .done       (cnt_done),
        .list_count (cnt_list),
        .total      (cnt_total)
    );

    a_result_from_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WAIT))
        else $error("result appeared outside the count update");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        dist_busy |-> !s_axis_tready)
        else $error("input accepted while distance pipeline busy");

    a_drained_before_bump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUMP) |-> !dist_busy)
        else $error("count update started before accumulators written back");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (CNT_W'(pass_idx_reg) < pass_end_reg))
        else $error("sweep index beyond end of pass");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_done |-> out_free)
        else $error("result overwrote an untaken transaction");

endmodule
